// File: hw/rtl/bilinear_crop_scale_top_defines.svh
// Assertion macros for the crop-and-scale top level.
`ifndef BILINEAR_CROP_SCALE_TOP_DEFINES_SVH
`define BILINEAR_CROP_SCALE_TOP_DEFINES_SVH

// Check a same-cycle implication on the rising clock edge, reset excluded.
`define BCS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the next cycle, reset excluded.
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/bcs_pkg.sv
// Shared constants and types for the bilinear crop-and-scale block.
`timescale 1ns / 1ps
package bcs_pkg;

	// Frame store geometry
	localparam int STORE_AW = 16;
	localparam int PIX_W = 32;

	// Source dimension limits and coordinate field width
	localparam int MAX_WIDTH = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int DIM_W = 9;
	localparam int COORD_W = 8;

	// Fixed point format
	localparam int FRAC_BITS_DEF = 16;
	localparam int RATIO_W = 25;

	// Channel lanes
	localparam int NUM_LANES = 4;
	localparam int BYTE_W = 8;
	localparam int CHAN_W = 3;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 25;
	localparam int PACK_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNELS    = 3'd0,
		REG_SOURCE_SIZE = 3'd1,
		REG_CROP_ORIGIN = 3'd2,
		REG_X_RATIO     = 3'd3,
		REG_Y_RATIO     = 3'd4,
		REG_BOX_ORIGIN  = 3'd5,
		REG_BOX_SIZE    = 3'd6,
		REG_PAD_COLOR   = 3'd7
	} cfg_reg_t;

	// Register reset values
	localparam logic [CHAN_W-1:0]  RST_CHANNELS = 3'd3;
	localparam logic [PACK_W-1:0]  RST_SOURCE_SIZE = 18'd131328;
	localparam logic [PACK_W-1:0]  RST_CROP_ORIGIN = 18'd0;
	localparam logic [RATIO_W-1:0] RST_RATIO = 25'd65536;
	localparam logic [PACK_W-1:0]  RST_BOX_ORIGIN = 18'd0;
	localparam logic [PACK_W-1:0]  RST_BOX_SIZE = 18'd131328;
	localparam logic [BYTE_W-1:0]  RST_PAD_COLOR = 8'd0;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

// File: hw/rtl/bilinear_crop_scale_top.sv
// Results leave from the registered last stage. One transaction per cycle, loads and
// requests alike, while the output does not stall; loads give no result.
// The four neighbor reads use two frame store copies, each read at two addresses a cycle.
// A stalled output holds the whole pipeline; the input stalls with it.
// Reset clears valid bits and loads register defaults; the frame store is not cleared.
`timescale 1ns / 1ps
module bilinear_crop_scale_top #(
	parameter int FRAC_BITS = bcs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic [bcs_pkg::STORE_AW-1:0]      load_index,
	input  logic [bcs_pkg::PIX_W-1:0]         load_pixel,
	input  logic [bcs_pkg::COORD_W-1:0]       out_x,
	input  logic [bcs_pkg::COORD_W-1:0]       out_y,
	// Result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bcs_pkg::PIX_W-1:0]         out_pixel,
	output logic                              in_box,
	// Configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bcs_pkg::*;

`include "bilinear_crop_scale_top_defines.svh"

	localparam int POS_W = COORD_W + RATIO_W;
	localparam int INT_W = POS_W - FRAC_BITS;
	localparam int PX_W = ((INT_W > DIM_W) ? INT_W : DIM_W) + 1;
	localparam int STORE_DEPTH = 1 << STORE_AW;

	// Configuration registers
	logic [CHAN_W-1:0]  channels_q;
	logic [PACK_W-1:0]  source_size_q;
	logic [PACK_W-1:0]  crop_origin_q;
	logic [RATIO_W-1:0] x_ratio_q;
	logic [RATIO_W-1:0] y_ratio_q;
	logic [PACK_W-1:0]  box_origin_q;
	logic [PACK_W-1:0]  box_size_q;
	byte_t              pad_color_q;

	logic adv;

	// Pipeline registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic req_s1, req_s2, req_s3, req_s4, req_s5, req_s6;
	logic box_s1, box_s2, box_s3, box_s4, box_s5, box_s6, box_s7;
	logic [STORE_AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [PIX_W-1:0]    pix_s1, pix_s2, pix_s3, pix_s4;
	logic [COORD_W-1:0]  dx_s1, dy_s1;
	logic [POS_W-1:0]    posx_s2, posy_s2;
	logic [STORE_AW-1:0] x0_s3, x1_s3, y0_s3, y1_s3;
	logic [STORE_AW-1:0] x0_s4, x1_s4, rowa_s4, rowc_s4;
	logic [FRAC_BITS-1:0] fx_s3, fy_s3, fx_s4, fy_s4, fx_s5, fy_s5;
	logic [PIX_W-1:0]    a_s5, b_s5, c_s5, d_s5;
	logic [PIX_W-1:0]    out_pixel_s7;

	// Frame store, two copies for four reads a cycle
	logic [PIX_W-1:0] mem_ab [STORE_DEPTH];
	logic [PIX_W-1:0] mem_cd [STORE_DEPTH];

	// Unpacked configuration fields
	logic [DIM_W-1:0] sw_raw, sh_raw, sw, sh, cx, cy, bx, by, bw, bh;
	logic             in_box_now;
	logic [PX_W-1:0]  px, py;
	logic             x_edge, y_edge;
	logic [STORE_AW-1:0] addr_a, addr_b, addr_c, addr_d;
	logic [PIX_W-1:0] blend;
	logic [PIX_W-1:0] lane_mask;
	logic [PIX_W-1:0] pad_word;

	// Advance the pipeline unless a finished result is held
	assign adv = !v_s7 || !out_stall;
	assign in_stall = !adv;
	assign cfg_ready = 1'b1;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q <= RST_CHANNELS;
			source_size_q <= RST_SOURCE_SIZE;
			crop_origin_q <= RST_CROP_ORIGIN;
			x_ratio_q <= RST_RATIO;
			y_ratio_q <= RST_RATIO;
			box_origin_q <= RST_BOX_ORIGIN;
			box_size_q <= RST_BOX_SIZE;
			pad_color_q <= RST_PAD_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_CHANNELS:    channels_q <= cfg_data[CHAN_W-1:0];
				REG_SOURCE_SIZE: source_size_q <= cfg_data[PACK_W-1:0];
				REG_CROP_ORIGIN: crop_origin_q <= cfg_data[PACK_W-1:0];
				REG_X_RATIO:     x_ratio_q <= cfg_data[RATIO_W-1:0];
				REG_Y_RATIO:     y_ratio_q <= cfg_data[RATIO_W-1:0];
				REG_BOX_ORIGIN:  box_origin_q <= cfg_data[PACK_W-1:0];
				REG_BOX_SIZE:    box_size_q <= cfg_data[PACK_W-1:0];
				REG_PAD_COLOR:   pad_color_q <= cfg_data[BYTE_W-1:0];
				default:         pad_color_q <= pad_color_q;
			endcase
		end
	end

	// Split packed fields and saturate source dimensions
	assign sw_raw = source_size_q[DIM_W-1:0];
	assign sh_raw = source_size_q[PACK_W-1:DIM_W];
	assign sw = (int'(sw_raw) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : sw_raw;
	assign sh = (int'(sh_raw) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : sh_raw;
	assign cx = crop_origin_q[DIM_W-1:0];
	assign cy = crop_origin_q[PACK_W-1:DIM_W];
	assign bx = box_origin_q[DIM_W-1:0];
	assign by = box_origin_q[PACK_W-1:DIM_W];
	assign bw = box_size_q[DIM_W-1:0];
	assign bh = box_size_q[PACK_W-1:DIM_W];

	// Test the request against the destination box
	assign in_box_now = ({1'b0, out_x} >= bx)
		&& ({2'b0, out_x} < ({1'b0, bx} + {1'b0, bw}))
		&& ({1'b0, out_y} >= by)
		&& ({2'b0, out_y} < ({1'b0, by} + {1'b0, bh}));

	// Valid and tag bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && req_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6 && req_s6;
		end
	end

	// Stage 1: capture the transaction and box offsets
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= func;
			box_s1 <= in_box_now;
			idx_s1 <= load_index;
			pix_s1 <= load_pixel;
			dx_s1 <= out_x - bx[COORD_W-1:0];
			dy_s1 <= out_y - by[COORD_W-1:0];
		end
	end

	// Stage 2: scale offsets by the ratios
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s2 <= req_s1;
			box_s2 <= box_s1;
			idx_s2 <= idx_s1;
			pix_s2 <= pix_s1;
			posx_s2 <= POS_W'(dx_s1) * POS_W'(x_ratio_q);
			posy_s2 <= POS_W'(dy_s1) * POS_W'(y_ratio_q);
		end
	end

	// Source coordinates and edge fold
	assign px = PX_W'(posx_s2[POS_W-1:FRAC_BITS]) + PX_W'(cx);
	assign py = PX_W'(posy_s2[POS_W-1:FRAC_BITS]) + PX_W'(cy);
	assign x_edge = (sw != '0) && (px == PX_W'(sw) - PX_W'(1));
	assign y_edge = (sh != '0) && (py == PX_W'(sh) - PX_W'(1));

	// Stage 3: neighbor coordinates and weights
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s3 <= req_s2;
			box_s3 <= box_s2;
			idx_s3 <= idx_s2;
			pix_s3 <= pix_s2;
			x0_s3 <= STORE_AW'(px);
			y0_s3 <= STORE_AW'(py);
			x1_s3 <= x_edge ? STORE_AW'(px) - STORE_AW'(1) : STORE_AW'(px) + STORE_AW'(1);
			y1_s3 <= y_edge ? STORE_AW'(py) - STORE_AW'(1) : STORE_AW'(py) + STORE_AW'(1);
			fx_s3 <= posx_s2[FRAC_BITS-1:0];
			fy_s3 <= posy_s2[FRAC_BITS-1:0];
		end
	end

	// Stage 4: row offsets, modulo store depth
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s4 <= req_s3;
			box_s4 <= box_s3;
			idx_s4 <= idx_s3;
			pix_s4 <= pix_s3;
			x0_s4 <= x0_s3;
			x1_s4 <= x1_s3;
			rowa_s4 <= y0_s3 * STORE_AW'(sw);
			rowc_s4 <= y1_s3 * STORE_AW'(sw);
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
		end
	end

	assign addr_a = rowa_s4 + x0_s4;
	assign addr_b = rowa_s4 + x1_s4;
	assign addr_c = rowc_s4 + x0_s4;
	assign addr_d = rowc_s4 + x1_s4;

	// Stage 5: write loads, read the upper neighbors
	always_ff @(posedge clk) begin
		if (adv && v_s4 && !req_s4) begin
			mem_ab[idx_s4] <= pix_s4;
		end
		if (adv) begin
			a_s5 <= mem_ab[addr_a];
			b_s5 <= mem_ab[addr_b];
		end
	end

	// Stage 5: write loads, read the lower neighbors
	always_ff @(posedge clk) begin
		if (adv && v_s4 && !req_s4) begin
			mem_cd[idx_s4] <= pix_s4;
		end
		if (adv) begin
			c_s5 <= mem_cd[addr_c];
			d_s5 <= mem_cd[addr_d];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s5 <= req_s4;
			box_s5 <= box_s4;
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
			req_s6 <= req_s5;
			box_s6 <= box_s5;
		end
	end

	// Stages 6 and 7: blend lanes
	bcs_blend #(
		.FRAC_BITS(FRAC_BITS)
	) u_blend (
		.clk   (clk),
		.en    (adv),
		.pix_a (a_s5),
		.pix_b (b_s5),
		.pix_c (c_s5),
		.pix_d (d_s5),
		.fx    (fx_s5),
		.fy    (fy_s5),
		.blend (blend)
	);

	// Active channel lanes and pad word
	always_comb begin
		lane_mask = '0;
		pad_word = '0;
		for (int k = 0; k < NUM_LANES; k++) begin
			if (k == 0 || int'(channels_q) > k) begin
				lane_mask[k*BYTE_W +: BYTE_W] = '1;
				pad_word[k*BYTE_W +: BYTE_W] = pad_color_q;
			end
		end
	end

	// Stage 7: select result and hold it for the consumer
	always_ff @(posedge clk) begin
		if (adv) begin
			box_s7 <= box_s6;
			out_pixel_s7 <= box_s6 ? (blend & lane_mask) : pad_word;
		end
	end

	assign out_valid = v_s7;
	assign out_pixel = out_pixel_s7;
	assign in_box = box_s7;

	`BCS_ASSERT_NOW(a_stall_back, out_valid && out_stall, in_stall, "input not stalled behind a held result")
	`BCS_ASSERT_NOW(a_pad_byte, out_valid && !in_box, out_pixel[BYTE_W-1:0] == pad_color_q, "pad result lacks pad color")
	`BCS_ASSERT_NOW(a_one_lane, out_valid && channels_q == CHAN_W'(1), out_pixel[PIX_W-1:BYTE_W] == '0, "unused channels not zero")
	`BCS_ASSERT_NEXT(a_load_silent, adv && v_s6 && !req_s6, !out_valid, "load transaction produced a result")
	`BCS_ASSERT_NEXT(a_hold_front, !adv, $stable(v_s1), "front stage moved during stall")

endmodule

// File: hw/rtl/bcs_blend.sv
// Per-channel bilinear blend lanes: horizontal pass registered, vertical pass after it.
`timescale 1ns / 1ps
module bcs_blend #(
	parameter int FRAC_BITS = bcs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [bcs_pkg::PIX_W-1:0]         pix_a,
	input  logic [bcs_pkg::PIX_W-1:0]         pix_b,
	input  logic [bcs_pkg::PIX_W-1:0]         pix_c,
	input  logic [bcs_pkg::PIX_W-1:0]         pix_d,
	input  logic [FRAC_BITS-1:0]              fx,
	input  logic [FRAC_BITS-1:0]              fy,
	output logic [bcs_pkg::PIX_W-1:0]         blend
);
	import bcs_pkg::*;

	localparam int WGT_W = FRAC_BITS + 1;
	localparam int TOP_W = FRAC_BITS + BYTE_W;
	localparam int SUM_W = 2 * FRAC_BITS + BYTE_W + 1;
	localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

	logic [WGT_W-1:0] wx0;
	logic [WGT_W-1:0] wx1;
	logic [WGT_W-1:0] wy0_s6;
	logic [WGT_W-1:0] wy1_s6;
	logic [TOP_W-1:0] top_s6 [NUM_LANES];
	logic [TOP_W-1:0] bot_s6 [NUM_LANES];

	// Form horizontal weights
	assign wx1 = {1'b0, fx};
	assign wx0 = ONE - wx1;

	// Register the vertical weights with the lanes
	always_ff @(posedge clk) begin
		if (en) begin
			wy1_s6 <= {1'b0, fy};
			wy0_s6 <= ONE - {1'b0, fy};
		end
	end

	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		byte_t va, vb, vc, vd;
		logic [SUM_W-1:0] sum;

		assign va = pix_a[k*BYTE_W +: BYTE_W];
		assign vb = pix_b[k*BYTE_W +: BYTE_W];
		assign vc = pix_c[k*BYTE_W +: BYTE_W];
		assign vd = pix_d[k*BYTE_W +: BYTE_W];

		// Blend along the row, exact
		always_ff @(posedge clk) begin
			if (en) begin
				top_s6[k] <= TOP_W'(TOP_W'(va) * TOP_W'(wx0) + TOP_W'(vb) * TOP_W'(wx1));
				bot_s6[k] <= TOP_W'(TOP_W'(vc) * TOP_W'(wx0) + TOP_W'(vd) * TOP_W'(wx1));
			end
		end

		// Blend along the column and truncate
		assign sum = SUM_W'(top_s6[k]) * SUM_W'(wy0_s6) + SUM_W'(bot_s6[k]) * SUM_W'(wy1_s6);
		assign blend[k*BYTE_W +: BYTE_W] = sum[2*FRAC_BITS +: BYTE_W];
	end

endmodule

// File: bench/bilinear_crop_scale_checker.sv
// Result predictor and scoreboard for the bilinear crop-and-scale block.
`timescale 1ns / 1ps
module bilinear_crop_scale_checker
	import bcs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   func,
	input  logic [STORE_AW-1:0]    load_index,
	input  logic [PIX_W-1:0]       load_pixel,
	input  logic [COORD_W-1:0]     out_x,
	input  logic [COORD_W-1:0]     out_y,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [PIX_W-1:0]       out_pixel,
	input  logic                   in_box,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending_count
);

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             boxed;
	} scaled_pixel_t;

	logic [PIX_W-1:0]      image_copy [0:(1<<STORE_AW)-1];
	logic [CHAN_W-1:0]     chan_reg;
	logic [PACK_W-1:0]     src_reg, crop_reg, box_org_reg, box_sz_reg;
	logic [RATIO_W-1:0]    xr_reg, yr_reg;
	logic [BYTE_W-1:0]     pad_reg;
	scaled_pixel_t         expected_pixels [$];

	assign pending_count = expected_pixels.size();

	function automatic logic [PIX_W-1:0] read_copy(int unsigned row, int unsigned col,
			int unsigned w);
		int unsigned addr;
		addr = row * w + col;
		return image_copy[addr[STORE_AW-1:0]];
	endfunction

	// Work out the scaled pixel for one destination coordinate
	function automatic scaled_pixel_t scale_pixel(logic [7:0] ox, logic [7:0] oy);
		scaled_pixel_t r;
		int unsigned nch, bx, by, bw, bh, sw, sh, cx, cy, px, py, x1, y1;
		longint unsigned posx, posy, fx, fy, s, sum, va, vb, vc, vd;
		logic [PIX_W-1:0] a, b, c, d;
		nch = chan_reg;
		if (nch == 0) nch = 1;
		if (nch > 4) nch = 4;
		bx = box_org_reg[8:0];
		by = box_org_reg[17:9];
		bw = box_sz_reg[8:0];
		bh = box_sz_reg[17:9];
		r.pixel = '0;
		if (ox < bx || ox >= bx + bw || oy < by || oy >= by + bh) begin
			for (int k = 0; k < nch; k++) r.pixel[8*k +: 8] = pad_reg;
			r.boxed = 1'b0;
			return r;
		end
		sw = src_reg[8:0];
		sh = src_reg[17:9];
		if (sw > MAX_WIDTH) sw = MAX_WIDTH;
		if (sh > MAX_HEIGHT) sh = MAX_HEIGHT;
		cx = crop_reg[8:0];
		cy = crop_reg[17:9];
		s = 64'd1 << FRAC_BITS_DEF;
		posx = longint'(ox - bx) * xr_reg;
		posy = longint'(oy - by) * yr_reg;
		px = int'(posx >> FRAC_BITS_DEF) + cx;
		py = int'(posy >> FRAC_BITS_DEF) + cy;
		fx = posx & (s - 1);
		fy = posy & (s - 1);
		x1 = (px == sw - 1) ? px - 1 : px + 1;
		y1 = (py == sh - 1) ? py - 1 : py + 1;
		a = read_copy(py, px, sw);
		b = read_copy(py, x1, sw);
		c = read_copy(y1, px, sw);
		d = read_copy(y1, x1, sw);
		for (int k = 0; k < nch; k++) begin
			va = a[8*k +: 8];
			vb = b[8*k +: 8];
			vc = c[8*k +: 8];
			vd = d[8*k +: 8];
			sum = va * (s - fx) * (s - fy) + vb * fx * (s - fy)
				+ vc * (s - fx) * fy + vd * fx * fy;
			r.pixel[8*k +: 8] = sum[2*FRAC_BITS_DEF +: 8];
		end
		r.boxed = 1'b1;
		return r;
	endfunction

	// Track registers, store writes, requests and results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_reg <= RST_CHANNELS;
			src_reg <= RST_SOURCE_SIZE;
			crop_reg <= RST_CROP_ORIGIN;
			xr_reg <= RST_RATIO;
			yr_reg <= RST_RATIO;
			box_org_reg <= RST_BOX_ORIGIN;
			box_sz_reg <= RST_BOX_SIZE;
			pad_reg <= RST_PAD_COLOR;
			fail_count <= 0;
			expected_pixels.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_CHANNELS:    chan_reg <= cfg_data[CHAN_W-1:0];
					REG_SOURCE_SIZE: src_reg <= cfg_data[PACK_W-1:0];
					REG_CROP_ORIGIN: crop_reg <= cfg_data[PACK_W-1:0];
					REG_X_RATIO:     xr_reg <= cfg_data;
					REG_Y_RATIO:     yr_reg <= cfg_data;
					REG_BOX_ORIGIN:  box_org_reg <= cfg_data[PACK_W-1:0];
					REG_BOX_SIZE:    box_sz_reg <= cfg_data[PACK_W-1:0];
					REG_PAD_COLOR:   pad_reg <= cfg_data[BYTE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (func == 1'b0) image_copy[load_index] = load_pixel;
				else expected_pixels.push_back(scale_pixel(out_x, out_y));
			end
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("result transaction with nothing expected: out_pixel %h", out_pixel);
					fail_count <= fail_count + 1;
				end else begin
					scaled_pixel_t e;
					e = expected_pixels.pop_front();
					if (out_pixel !== e.pixel || in_box !== e.boxed) begin
						if (out_pixel !== e.pixel)
							$error("out_pixel expected %h actual %h", e.pixel, out_pixel);
						if (in_box !== e.boxed)
							$error("in_box expected %b actual %b", e.boxed, in_box);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// File: bench/bilinear_crop_scale_top_tb.sv
// Stimulus, flow control and verdict for the bilinear crop-and-scale block.
`timescale 1ns / 1ps
module bilinear_crop_scale_top_tb;
	import bcs_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = 1'b0;
	logic [STORE_AW-1:0] load_index = '0;
	logic [PIX_W-1:0] load_pixel = '0;
	logic [COORD_W-1:0] out_x = '0;
	logic [COORD_W-1:0] out_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] out_pixel;
	logic in_box;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count, pending_count;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// Shadow of register values and of which store entries hold data
	logic [CFG_DATA_W-1:0] shadow [0:7];
	bit loaded [0:(1<<STORE_AW)-1];

	bilinear_crop_scale_top i_dut (.*);

	bilinear_crop_scale_checker i_chk (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Drive receiver stall, including one long hold
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Count cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Check that all four neighbors of a request inside the box were loaded
	function automatic bit request_safe(logic [7:0] ox, logic [7:0] oy);
		int unsigned bx, by, bw, bh, sw, sh, px, py, x1, y1;
		int unsigned addr [4];
		longint unsigned posx, posy;
		bx = shadow[REG_BOX_ORIGIN][8:0];
		by = shadow[REG_BOX_ORIGIN][17:9];
		bw = shadow[REG_BOX_SIZE][8:0];
		bh = shadow[REG_BOX_SIZE][17:9];
		if (ox < bx || ox >= bx + bw || oy < by || oy >= by + bh) return 1'b1;
		sw = shadow[REG_SOURCE_SIZE][8:0];
		sh = shadow[REG_SOURCE_SIZE][17:9];
		if (sw > MAX_WIDTH) sw = MAX_WIDTH;
		if (sh > MAX_HEIGHT) sh = MAX_HEIGHT;
		posx = longint'(ox - bx) * shadow[REG_X_RATIO];
		posy = longint'(oy - by) * shadow[REG_Y_RATIO];
		px = int'(posx >> FRAC_BITS_DEF) + shadow[REG_CROP_ORIGIN][8:0];
		py = int'(posy >> FRAC_BITS_DEF) + shadow[REG_CROP_ORIGIN][17:9];
		x1 = (px == sw - 1) ? px - 1 : px + 1;
		y1 = (py == sh - 1) ? py - 1 : py + 1;
		addr[0] = py * sw + px;
		addr[1] = py * sw + x1;
		addr[2] = y1 * sw + px;
		addr[3] = y1 * sw + x1;
		foreach (addr[i]) if (!loaded[addr[i][15:0]]) return 1'b0;
		return 1'b1;
	endfunction

	// Offer one transaction and wait until it is taken
	task automatic send_item(logic f, logic [15:0] idx, logic [31:0] pix,
			logic [7:0] x, logic [7:0] y);
		bit stalled;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		func <= f;
		load_index <= idx;
		load_pixel <= pix;
		out_x <= x;
		out_y <= y;
		in_valid <= 1'b1;
		if (f == 1'b0) loaded[idx] = 1'b1;
		forever begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
			if (!stalled) break;
		end
	endtask

	task automatic send_load(logic [15:0] idx, logic [31:0] pix);
		send_item(1'b0, idx, pix, 8'($urandom), 8'($urandom));
	endtask

	// Issue a request if safe, else fall back to a load
	task automatic send_request(logic [7:0] x, logic [7:0] y);
		if (request_safe(x, y)) send_item(1'b1, 16'($urandom), $urandom, x, y);
		else send_load(16'($urandom_range(255)), $urandom);
	endtask

	// Write one register; the caller drops valid after the last one
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		bit ready_seen;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		shadow[idx] = value;
		forever begin
			@(negedge clk);
			ready_seen = cfg_ready;
			@(posedge clk);
			if (ready_seen) break;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_phase(int ch, int sw, int sh, int cx, int cy, int xr, int yr,
			int bx, int by, int bw, int bh, int pad);
		drain();
		write_reg(REG_CHANNELS, CFG_DATA_W'(ch));
		write_reg(REG_SOURCE_SIZE, CFG_DATA_W'(sh * 512 + sw));
		write_reg(REG_CROP_ORIGIN, CFG_DATA_W'(cy * 512 + cx));
		write_reg(REG_X_RATIO, CFG_DATA_W'(xr));
		write_reg(REG_Y_RATIO, CFG_DATA_W'(yr));
		write_reg(REG_BOX_ORIGIN, CFG_DATA_W'(by * 512 + bx));
		write_reg(REG_BOX_SIZE, CFG_DATA_W'(bh * 512 + bw));
		write_reg(REG_PAD_COLOR, CFG_DATA_W'(pad));
		cfg_valid <= 1'b0;
	endtask

	// Random mix of requests, mostly inside the box, and loads
	task automatic random_items(int count, int span);
		int bx, by, bw, bh;
		logic [7:0] x, y;
		bx = shadow[REG_BOX_ORIGIN][8:0];
		by = shadow[REG_BOX_ORIGIN][17:9];
		bw = shadow[REG_BOX_SIZE][8:0];
		bh = shadow[REG_BOX_SIZE][17:9];
		repeat (count) begin
			if ($urandom_range(99) < 30) begin
				if ($urandom_range(99) < 20) send_load(16'($urandom), $urandom);
				else send_load(16'($urandom_range(span - 1)), $urandom);
			end else begin
				x = 8'($urandom);
				y = 8'($urandom);
				for (int t = 0; t < 8; t++) begin
					if ($urandom_range(99) < 80 && bw > 0 && bh > 0) begin
						x = 8'(bx + int'($urandom_range(bw - 1)));
						y = 8'(by + int'($urandom_range(bh - 1)));
					end else begin
						x = 8'($urandom);
						y = 8'($urandom);
					end
					if (request_safe(x, y)) break;
				end
				send_request(x, y);
			end
		end
	endtask

	task automatic fill_source(int count);
		for (int i = 0; i < count; i++) send_load(16'(i), $urandom);
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 76; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 76; end
			default: begin idle_pct = 30; stall_pct = 30; end
		endcase
	endtask

	initial begin
		shadow[REG_CHANNELS] = CFG_DATA_W'(RST_CHANNELS);
		shadow[REG_SOURCE_SIZE] = CFG_DATA_W'(RST_SOURCE_SIZE);
		shadow[REG_CROP_ORIGIN] = CFG_DATA_W'(RST_CROP_ORIGIN);
		shadow[REG_X_RATIO] = RST_RATIO;
		shadow[REG_Y_RATIO] = RST_RATIO;
		shadow[REG_BOX_ORIGIN] = CFG_DATA_W'(RST_BOX_ORIGIN);
		shadow[REG_BOX_SIZE] = CFG_DATA_W'(RST_BOX_SIZE);
		shadow[REG_PAD_COLOR] = CFG_DATA_W'(RST_PAD_COLOR);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: loads and a request at reset values, then extremes on a small source
		set_idling(0);
		send_load(16'hFFFF, 32'hFFFF_FFFF);
		send_load(16'h0000, 32'h0000_0000);
		send_request(8'd255, 8'd255);
		set_phase(3, 8, 6, 0, 0, 65536, 65536, 0, 0, 10, 10, 8'h5A);
		fill_source(48);
		send_load(16'd0, 32'hFFFF_FFFF);
		send_load(16'd1, 32'h0000_0000);
		send_request(8'd0, 8'd0);
		send_request(8'd7, 8'd0);
		send_request(8'd0, 8'd5);
		send_request(8'd7, 8'd5);
		send_request(8'd9, 8'd9);
		send_request(8'd10, 8'd3);
		send_request(8'd3, 8'd10);
		send_request(8'd255, 8'd255);
		set_phase(4, 8, 6, 0, 0, 32768, 16384, 0, 0, 8, 8, 8'hFF);
		send_request(8'd1, 8'd1);
		send_request(8'd7, 8'd7);
		send_request(8'd20, 8'd0);

		// Fill the pipeline behind a long receiver hold
		hold_req = 1'b1;
		random_items(60, 48);
		hold_req = 1'b0;

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_phase(1, 16, 12, 1, 2, 'h0A000, 'h1C000, 3, 4, 20, 20, 255);
				1: set_phase(4, 511, 2, 0, 0, 'h08000, 'h0C000, 0, 0, 300, 2, 8'h11);
				2: set_phase(0, 0, 0, 0, 3, 0, 0, 5, 5, 40, 40, 0);
				3: set_phase(7, 4, 4, 1, 1, 16777216, 16777216, 250, 250, 511, 511, 8'h81);
				4: set_phase(2, 6, 5, 0, 0, 65536, 65536, 0, 0, 0, 0, 8'hC3);
				5: set_phase(2, 5, 3, 511, 511, 'h04000, 'h04000, 2, 2, 50, 50, 8'h3C);
				6: set_phase(3, 9, 7, 0, 0, 'h18000, 'h0B333, 0, 0, 256, 256, 8'hA5);
				default: set_phase(3, 256, 256, 0, 0, 65536, 65536, 0, 0, 256, 256, 0);
			endcase
			set_idling(p);
			case (p)
				1: fill_source(385);
				2: fill_source(16);
				3: fill_source(16);
				4: fill_source(30);
				5: fill_source(15);
				6: fill_source(63);
				7: fill_source(64);
				default: fill_source(192);
			endcase
			random_items(p == 7 ? 30 : 24, p == 7 ? 64 : 512);
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bcs_pkg.sv
hw/rtl/bcs_blend.sv
hw/rtl/bilinear_crop_scale_top.sv
bench/bilinear_crop_scale_checker.sv
bench/bilinear_crop_scale_top_tb.sv
